// File: rtl/wmd_pkg.sv
// shared types and constants of the wbmp type 0 decoder
package wmd_pkg;

    localparam int DIM_W   = 17;
    localparam int BYTES_W = 27;
    localparam int ACC_W   = 28;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;

    localparam logic [DIM_W-1:0]   SIDE_LIMIT     = 17'd65536;
    localparam logic [BYTES_W-1:0] BYTES_SAT      = 27'h7FFFFFF;
    localparam logic [BYTES_W-1:0] HDR_MIN_BYTES  = 27'd4;
    localparam logic [DIM_W-1:0]   MAX_DIM_RST    = 17'd65536;
    localparam logic [BYTES_W-1:0] MAX_FILE_RST   = 27'd67108864;
    localparam logic [CNT_W-1:0]   FIELD_MAX_BYTES = 3'd4;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_TOO_LONG  = 3'd0,
        ERR_BAD_TYPE  = 3'd1,
        ERR_BAD_DIM   = 3'd2,
        ERR_TRUNCATED = 3'd3,
        ERR_TOO_LARGE = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        CFG_MAX_DIM     = 2'd0,
        CFG_MAX_FILE    = 2'd1,
        CFG_HEADER_ONLY = 2'd2
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_TYPE   = 7'b0000001,
        PH_FIX    = 7'b0000010,
        PH_WIDTH  = 7'b0000100,
        PH_HEIGHT = 7'b0001000,
        PH_PIX    = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERR    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [DIM_W-1:0]   max_dim;
        logic [BYTES_W-1:0] max_file;
        logic               header_only;
    } t_cfg;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       pix_byte;
        logic [3:0]       npix;
        logic             eor;
        logic             eoi;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        t_err             err;
    } t_cmd;

endpackage

// File: rtl/wmd_if.sv
// channel interfaces: file bytes in, results out, register writes

interface wmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [16:0] image_width;
    logic [16:0] image_height;
    logic [2:0]  error_code;
    logic        end_of_row;
    logic        end_of_image;
    logic        last_result;

    modport source (output valid, output kind, output pixel_value, output image_width,
                    output image_height, output error_code, output end_of_row,
                    output end_of_image, output last_result, input ready);
    modport sink   (input valid, input kind, input pixel_value, input image_width,
                    input image_height, input error_code, input end_of_row,
                    input end_of_image, input last_result, output ready);
endinterface

interface wmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [26:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/wmd_front.sv
// header parser and byte classifier, issues at most one command per byte
module wmd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wmd_pkg::t_cfg i_cfg,
    wmd_in_if.sink        i_byte,
    input  logic          i_full,
    output logic          o_push,
    output wmd_pkg::t_cmd o_cmd
);

    wmd_pkg::t_phase r_phase, n_phase;
    logic [wmd_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [wmd_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [wmd_pkg::DIM_W-1:0]   r_width, n_width;
    logic [wmd_pkg::DIM_W-1:0]   r_height, n_height;
    logic [wmd_pkg::DIM_W-1:0]   r_col, n_col;
    logic [wmd_pkg::DIM_W-1:0]   r_row, n_row;
    logic [wmd_pkg::BYTES_W-1:0] r_bytes, n_bytes;

    logic                          accept;
    logic [7:0]                    b;
    logic                          last;
    logic [wmd_pkg::BYTES_W-1:0]   bs_n;
    logic [wmd_pkg::DIM_W-1:0]     lim;
    logic [wmd_pkg::ACC_W-1:0]     acc_n;
    logic [wmd_pkg::ACC_W-1:0]     lim_x;
    logic [wmd_pkg::CNT_W-1:0]     cnt_n;
    logic                          fdone;
    logic                          ftoolong;
    logic                          dim_ok;
    logic [wmd_pkg::DIM_W-1:0]     rem;
    logic                          eor;
    logic [wmd_pkg::DIM_W-1:0]     row_inc;
    logic                          last_row;
    logic                          completes;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;
    assign b            = i_byte.data_byte;
    assign last         = i_byte.last_byte;

    always_comb begin
        bs_n      = (r_bytes == wmd_pkg::BYTES_SAT) ? r_bytes
                                                    : r_bytes + wmd_pkg::BYTES_W'(1);
        lim       = (i_cfg.max_dim > wmd_pkg::SIDE_LIMIT) ? wmd_pkg::SIDE_LIMIT
                                                          : i_cfg.max_dim;
        lim_x     = {{(wmd_pkg::ACC_W - wmd_pkg::DIM_W){1'b0}}, lim};
        acc_n     = {r_acc[wmd_pkg::ACC_W-8:0], b[6:0]};
        cnt_n     = r_cnt + wmd_pkg::CNT_W'(1);
        fdone     = !b[7];
        ftoolong  = b[7] && (cnt_n >= wmd_pkg::FIELD_MAX_BYTES);
        dim_ok    = (acc_n != '0) && (acc_n <= lim_x);
        rem       = r_width - r_col;
        eor       = (rem <= wmd_pkg::DIM_W'(8));
        row_inc   = r_row + wmd_pkg::DIM_W'(1);
        last_row  = (row_inc == r_height);
        completes = last_row && eor;
    end

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_bytes  = r_bytes;
        o_push   = 1'b0;
        o_cmd    = '0;

        if (accept) begin
            n_bytes = bs_n;
            if (r_phase != wmd_pkg::PH_ERR && bs_n > i_cfg.max_file) begin
                o_push     = 1'b1;
                o_cmd.kind = wmd_pkg::KIND_ERROR;
                o_cmd.err  = wmd_pkg::ERR_TOO_LARGE;
                n_phase    = wmd_pkg::PH_ERR;
            end else begin
                case (r_phase)
                    wmd_pkg::PH_TYPE, wmd_pkg::PH_WIDTH, wmd_pkg::PH_HEIGHT: begin
                        n_acc = acc_n;
                        n_cnt = cnt_n;
                        if (ftoolong) begin
                            o_push     = 1'b1;
                            o_cmd.kind = wmd_pkg::KIND_ERROR;
                            o_cmd.err  = wmd_pkg::ERR_TOO_LONG;
                            n_phase    = wmd_pkg::PH_ERR;
                        end else if (fdone) begin
                            n_cnt = '0;
                            n_acc = '0;
                            if (r_phase == wmd_pkg::PH_TYPE) begin
                                if (acc_n != '0) begin
                                    o_push     = 1'b1;
                                    o_cmd.kind = wmd_pkg::KIND_ERROR;
                                    o_cmd.err  = wmd_pkg::ERR_BAD_TYPE;
                                    n_phase    = wmd_pkg::PH_ERR;
                                end else begin
                                    n_phase = wmd_pkg::PH_FIX;
                                end
                            end else if (r_phase == wmd_pkg::PH_WIDTH) begin
                                // a bad width is kept as zero and reported after the height
                                n_width = dim_ok ? acc_n[wmd_pkg::DIM_W-1:0] : '0;
                                n_phase = wmd_pkg::PH_HEIGHT;
                            end else if (r_width == '0 || !dim_ok) begin
                                o_push     = 1'b1;
                                o_cmd.kind = wmd_pkg::KIND_ERROR;
                                o_cmd.err  = wmd_pkg::ERR_BAD_DIM;
                                n_phase    = wmd_pkg::PH_ERR;
                            end else begin
                                n_height     = acc_n[wmd_pkg::DIM_W-1:0];
                                n_col        = '0;
                                n_row        = '0;
                                o_cmd.width  = r_width;
                                o_cmd.height = acc_n[wmd_pkg::DIM_W-1:0];
                                if (i_cfg.header_only) begin
                                    if (last && bs_n <= wmd_pkg::HDR_MIN_BYTES) begin
                                        o_push     = 1'b1;
                                        o_cmd.kind = wmd_pkg::KIND_ERROR;
                                        o_cmd.err  = wmd_pkg::ERR_TRUNCATED;
                                        n_phase    = wmd_pkg::PH_ERR;
                                    end else begin
                                        o_push     = 1'b1;
                                        o_cmd.kind = wmd_pkg::KIND_HEADER;
                                        n_phase    = wmd_pkg::PH_DONE;
                                    end
                                end else begin
                                    if (!last) begin
                                        o_push     = 1'b1;
                                        o_cmd.kind = wmd_pkg::KIND_HEADER;
                                    end
                                    n_phase = wmd_pkg::PH_PIX;
                                end
                            end
                        end
                    end
                    wmd_pkg::PH_FIX: begin
                        n_phase = wmd_pkg::PH_WIDTH;
                    end
                    wmd_pkg::PH_PIX: begin
                        if (!last || completes) begin
                            o_push         = 1'b1;
                            o_cmd.kind     = wmd_pkg::KIND_PIXEL;
                            o_cmd.pix_byte = b;
                            o_cmd.npix     = eor ? rem[3:0] : 4'd8;
                            o_cmd.eor      = eor;
                            o_cmd.eoi      = completes;
                            if (eor) begin
                                n_col = '0;
                                n_row = row_inc;
                                if (last_row) begin
                                    n_phase = wmd_pkg::PH_DONE;
                                end
                            end else begin
                                n_col = r_col + wmd_pkg::DIM_W'(8);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (last && n_phase != wmd_pkg::PH_DONE && n_phase != wmd_pkg::PH_ERR) begin
                o_push     = 1'b1;
                o_cmd      = '0;
                o_cmd.kind = wmd_pkg::KIND_ERROR;
                o_cmd.err  = wmd_pkg::ERR_TRUNCATED;
                n_phase    = wmd_pkg::PH_ERR;
            end

            // ready for the next file
            if (last) begin
                n_phase  = wmd_pkg::PH_TYPE;
                n_acc    = '0;
                n_cnt    = '0;
                n_width  = '0;
                n_height = '0;
                n_col    = '0;
                n_row    = '0;
                n_bytes  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wmd_pkg::PH_TYPE;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_bytes  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_bytes  <= n_bytes;
        end
    end

endmodule

// File: rtl/wmd_queue.sv
// command queue between parser and result expander
module wmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wmd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output wmd_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wmd_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/wmd_back.sv
// result expander: one result word per cycle into the output register while the result channel is ready
module wmd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  wmd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    wmd_out_if.source     o_result
);

    logic [wmd_pkg::IDX_W-1:0] r_idx;
    logic                      r_valid;
    logic [1:0]                r_kind;
    logic [7:0]                r_pixel;
    logic [16:0]               r_width;
    logic [16:0]               r_height;
    logic [2:0]                r_err;
    logic                      r_eor;
    logic                      r_eoi;
    logic                      r_last;

    logic load;
    logic is_pix;
    logic last_of;

    assign load    = !r_valid || o_result.ready;
    assign is_pix  = (i_cmd.kind == wmd_pkg::KIND_PIXEL);
    assign last_of = !is_pix || (({1'b0, r_idx} + 4'd1) == i_cmd.npix);
    assign o_pop   = load && !i_empty && last_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= last_of ? '0 : r_idx + wmd_pkg::IDX_W'(1);
            end
        end
    end

    // pixels go out msb first
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind   <= i_cmd.kind;
            r_pixel  <= (is_pix && i_cmd.pix_byte[~r_idx]) ? 8'hFF : 8'h00;
            r_width  <= (i_cmd.kind == wmd_pkg::KIND_HEADER) ? i_cmd.width : '0;
            r_height <= (i_cmd.kind == wmd_pkg::KIND_HEADER) ? i_cmd.height : '0;
            r_err    <= (i_cmd.kind == wmd_pkg::KIND_ERROR) ? i_cmd.err : '0;
            r_eor    <= is_pix && last_of && i_cmd.eor;
            r_eoi    <= is_pix && last_of && i_cmd.eoi;
            r_last   <= last_of;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.kind         = r_kind;
    assign o_result.pixel_value  = r_pixel;
    assign o_result.image_width  = r_width;
    assign o_result.image_height = r_height;
    assign o_result.error_code   = r_err;
    assign o_result.end_of_row   = r_eor;
    assign o_result.end_of_image = r_eoi;
    assign o_result.last_result  = r_last;

endmodule

// File: rtl/wbmp_monochrome_image_decoder.sv
// WBMP type 0 decoder top level. The parser takes one file byte per cycle whenever its
// command queue has room and turns it into at most one command: a header report, an
// error, or a packed pixel byte. The expander drains the queue and sends one result
// word per cycle through a registered output while the result channel is ready. A
// pixel byte yields one to eight result words and every other command one, so the
// expander sets pixel throughput. A byte that finds the queue empty passes the queue
// memory and then the output register. Registers must be written only while the block
// is idle; the block itself does not enforce this. The register port is always ready.
module wbmp_monochrome_image_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wmd_in_if.sink    i_byte,
    wmd_cfg_if.sink   i_cfg,
    wmd_out_if.source o_result
);

    wmd_pkg::t_cfg r_cfg;
    wmd_pkg::t_cmd push_cmd, head_cmd;
    logic          push, pop, full, empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_dim     <= wmd_pkg::MAX_DIM_RST;
            r_cfg.max_file    <= wmd_pkg::MAX_FILE_RST;
            r_cfg.header_only <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wmd_pkg::CFG_MAX_DIM:     r_cfg.max_dim     <= i_cfg.data[wmd_pkg::DIM_W-1:0];
                wmd_pkg::CFG_MAX_FILE:    r_cfg.max_file    <= i_cfg.data;
                wmd_pkg::CFG_HEADER_ONLY: r_cfg.header_only <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    wmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    wmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    wmd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// File: rtl/wmd_checker.sv
// port-level checks on the result channel, bound to the top level
module wmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_pixel_value,
    input logic [16:0] i_image_width,
    input logic [16:0] i_image_height,
    input logic [2:0]  i_error_code,
    input logic        i_end_of_row,
    input logic        i_end_of_image,
    input logic        i_last_result
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_pixel_value)
            && $stable(i_image_width) && $stable(i_image_height) && $stable(i_error_code)
            && $stable(i_end_of_row) && $stable(i_end_of_image) && $stable(i_last_result))
        else $error("result word changed while stalled");

    // image end is always a row end of a pixel word
    a_eoi_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_end_of_image |-> i_end_of_row && i_kind == wmd_pkg::KIND_PIXEL)
        else $error("end of image without end of row");

    // header stands alone and has real dimensions
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == wmd_pkg::KIND_HEADER |->
            i_image_width != '0 && i_image_height != '0 && i_last_result)
        else $error("bad header word");

    // pixel words are black or white with no error code
    a_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == wmd_pkg::KIND_PIXEL |->
            (i_pixel_value == 8'h00 || i_pixel_value == 8'hFF) && i_error_code == '0)
        else $error("bad pixel word");

endmodule

bind wbmp_monochrome_image_decoder wmd_checker u_wmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_kind         (o_result.kind),
    .i_pixel_value  (o_result.pixel_value),
    .i_image_width  (o_result.image_width),
    .i_image_height (o_result.image_height),
    .i_error_code   (o_result.error_code),
    .i_end_of_row   (o_result.end_of_row),
    .i_end_of_image (o_result.end_of_image),
    .i_last_result  (o_result.last_result)
);
